### rtl/pra_pkg.sv
// Shared types and constants for the pool range allocator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pra_pkg;

	// Fixed field widths
	localparam int DATA_W   = 32;
	localparam int ALOG_W   = 5;
	localparam int STATUS_W = 2;
	localparam int LIVE_W   = 7;
	localparam int MODE_W   = 2;
	localparam int CIDX_W   = 2;
	// Span arithmetic needs room for rounding carries
	localparam int SPAN_W   = DATA_W + 3;

	// Request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_POOL_BYTES = 2'd0;
	localparam logic [CIDX_W-1:0] REG_POOL_ALIGN = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FREE_ORDER = 2'd2;

	// Free list ordering modes (any mode with the upper bit set is newest first)
	localparam logic [MODE_W-1:0] ORDER_SIZE   = 2'd0;
	localparam logic [MODE_W-1:0] ORDER_OFFSET = 2'd1;

	// Reset values of the configuration registers
	localparam logic [DATA_W-1:0] POOL_BYTES_RST = 32'd65536;
	localparam logic [ALOG_W-1:0] POOL_ALIGN_RST = 5'd8;
	localparam logic [MODE_W-1:0] FREE_ORDER_RST = ORDER_SIZE;

endpackage

`default_nettype wire

### rtl/pra_if.sv
// Handshake channels of the pool range allocator: request, result, configuration.
// Depends on pra_pkg for field widths and the status type.
`default_nettype none

interface pra_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [pra_pkg::DATA_W-1:0]  request_bytes;
	logic [pra_pkg::ALOG_W-1:0]  align_log2;
	logic [pra_pkg::DATA_W-1:0]  release_offset;

	modport source (output valid, req_type, request_bytes, align_log2, release_offset,
		input ready);
	modport sink (input valid, req_type, request_bytes, align_log2, release_offset,
		output ready);
endinterface

interface pra_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pra_pkg::STATUS_W-1:0] status;
	logic [pra_pkg::DATA_W-1:0]  grant_offset;
	logic [pra_pkg::DATA_W-1:0]  free_bytes;
	logic [pra_pkg::DATA_W-1:0]  waste_bytes;
	logic [pra_pkg::LIVE_W-1:0]  live_count;

	modport source (output valid, status, grant_offset, free_bytes, waste_bytes, live_count,
		input ready);
	modport sink (input valid, status, grant_offset, free_bytes, waste_bytes, live_count,
		output ready);
endinterface

interface pra_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [pra_pkg::CIDX_W-1:0]  index;
	logic [pra_pkg::DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/pool_range_allocator_core.sv
// Top level of the pool range allocator: segment table and free list memories
// with the request sequencer. Depends on pra_pkg and the channels in pra_if.sv.
//
// First-fit range allocator with neighbor coalescing. The segment table and the
// ordered free list each live in a synchronous memory (one read, one write per
// cycle, registered read data); every request is worked by a sequencer that
// walks these memories. An allocate request reads and compares each free-list
// entry it examines, skipping early an entry that names no table entry, then
// moves or renumbers entries when the free list and table are reordered and
// compares free-list entries while inserting the new free segment. A free
// request searches the table, searches the free list for each merged neighbor
// and does the same reordering work. One request is in work at a time; a
// finished result waits in the output register while the next request is
// taken. Configuration writes are taken only while no request is in work.
// After reset and after a write of pool_bytes or pool_align_log2 the pool is
// rebuilt before the next request is taken.
`default_nettype none

module pool_range_allocator_core #(
	parameter int MAX_SEGMENTS = 64,
	parameter int ADDR_BITS    = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	pra_req_if.sink      req,
	pra_rsp_if.source    rsp,
	pra_cfg_if.sink      cfg
);

	localparam int DW = pra_pkg::DATA_W;
	localparam int SW = pra_pkg::SPAN_W;
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int NS = 37;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] length;
		logic                 in_use;
		logic [DW-1:0]        asked;
		logic [ADDR_BITS-1:0] grant;
	} seg_t;

	typedef enum logic [NS-1:0] {
		S_INIT  = NS'(1) << 0,
		S_IDLE  = NS'(1) << 1,
		S_APREP = NS'(1) << 2,
		S_AFL   = NS'(1) << 3,
		S_ASEG  = NS'(1) << 4,
		S_AAT   = NS'(1) << 5,
		S_ACMP  = NS'(1) << 6,
		S_AOPN  = NS'(1) << 7,
		S_AWRN  = NS'(1) << 8,
		S_AWRP  = NS'(1) << 9,
		S_AFIN  = NS'(1) << 10,
		S_FRD   = NS'(1) << 11,
		S_FCHK  = NS'(1) << 12,
		S_FLRD  = NS'(1) << 13,
		S_FLCHK = NS'(1) << 14,
		S_FLMRG = NS'(1) << 15,
		S_FRRD  = NS'(1) << 16,
		S_FRCHK = NS'(1) << 17,
		S_FRMRG = NS'(1) << 18,
		S_FWR   = NS'(1) << 19,
		S_RMRD  = NS'(1) << 20,
		S_RMWR  = NS'(1) << 21,
		S_FDRD  = NS'(1) << 22,
		S_FDCHK = NS'(1) << 23,
		S_OPRD  = NS'(1) << 24,
		S_OPWR  = NS'(1) << 25,
		S_CLRD  = NS'(1) << 26,
		S_CLWR  = NS'(1) << 27,
		S_ADRD  = NS'(1) << 28,
		S_ADWR  = NS'(1) << 29,
		S_INS   = NS'(1) << 30,
		S_SCFL  = NS'(1) << 31,
		S_SCSEG = NS'(1) << 32,
		S_SCCMP = NS'(1) << 33,
		S_SHRD  = NS'(1) << 34,
		S_SHWR  = NS'(1) << 35,
		S_DONE  = NS'(1) << 36
	} state_t;

	// Memories
	seg_t           seg_mem [MAX_SEGMENTS];
	logic [IW-1:0]  fl_mem  [MAX_SEGMENTS];

	logic           seg_we;
	logic [IW-1:0]  seg_wa, seg_ra;
	seg_t           seg_wd;
	seg_t           seg_rd_q;
	logic           fl_we;
	logic [IW-1:0]  fl_wa, fl_ra, fl_wd;
	logic [IW-1:0]  fl_rd_q;

	// Control and working registers
	state_t                        state_q, ret_q;
	logic [DW-1:0]                 pool_bytes_q;
	logic [pra_pkg::ALOG_W-1:0]    pool_align_q;
	logic [pra_pkg::MODE_W-1:0]    order_q;
	logic [CW-1:0]                 seg_total_q, fl_len_q, live_q;
	logic [DW-1:0]                 free_q, waste_q;

	logic [DW-1:0]                 bytes_q, off_q;
	logic [pra_pkg::ALOG_W-1:0]    alog_q;
	logic [SW-1:0]                 amask_q, need_q, at_q, taken_q;
	logic [CW-1:0]                 i_q, j_q, k_q, pos_q, thr_q;
	logic [IW-1:0]                 p_q, target_q, ins_seg_q;
	logic [ADDR_BITS-1:0]          st_q, len_q, cur_st_q, cur_len_q, ins_key_q;
	logic                          adj_inc_q;
	pra_pkg::status_t              res_status_q;
	logic [DW-1:0]                 res_grant_q;

	logic                          out_valid_q;
	pra_pkg::status_t              out_status_q;
	logic [DW-1:0]                 out_grant_q, out_free_q, out_waste_q;
	logic [pra_pkg::LIVE_W-1:0]    out_live_q;

	// Combinational helpers
	logic [ADDR_BITS-1:0]          size_w;
	logic [pra_pkg::ALOG_W-1:0]    l2_w;
	logic [SW-1:0]                 amask_w, taken_w;
	logic [ADDR_BITS-1:0]          rem_start_w, rem_len_w, key_field_w;
	logic                          req_acc, cfg_acc, out_load;

	assign size_w      = pool_bytes_q[ADDR_BITS-1:0];
	assign l2_w        = (pool_align_q > alog_q) ? pool_align_q : alog_q;
	assign amask_w     = SW'((SW'(1) << l2_w) - SW'(1));
	assign taken_w     = (at_q - SW'(st_q)) + need_q;
	assign rem_start_w = ADDR_BITS'(SW'(st_q) + taken_q);
	assign rem_len_w   = ADDR_BITS'(SW'(len_q) - taken_q);
	assign key_field_w = (order_q == pra_pkg::ORDER_SIZE) ? seg_rd_q.length : seg_rd_q.start;

	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = (state_q == S_IDLE);
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.grant_offset = out_grant_q;
	assign rsp.free_bytes   = out_free_q;
	assign rsp.waste_bytes  = out_waste_q;
	assign rsp.live_count   = out_live_q;

	// Segment table memory
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_wa] <= seg_wd;
		end
		seg_rd_q <= seg_mem[seg_ra];
	end

	// Free list memory
	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[fl_wa] <= fl_wd;
		end
		fl_rd_q <= fl_mem[fl_ra];
	end

	// Drive memory ports from the sequencer state
	always_comb begin
		seg_we = 1'b0;
		seg_wa = '0;
		seg_wd = '0;
		seg_ra = '0;
		fl_we  = 1'b0;
		fl_wa  = '0;
		fl_wd  = '0;
		fl_ra  = '0;
		case (state_q)
			S_INIT: begin
				seg_we        = 1'b1;
				seg_wd.length = size_w;
				fl_we         = 1'b1;
			end
			S_AFL: fl_ra = i_q[IW-1:0];
			S_ASEG: seg_ra = fl_rd_q;
			S_AWRN: begin
				seg_we       = 1'b1;
				seg_wa       = IW'(p_q + 1'b1);
				seg_wd.start  = rem_start_w;
				seg_wd.length = rem_len_w;
			end
			S_AWRP: begin
				seg_we        = 1'b1;
				seg_wa        = p_q;
				seg_wd.start  = st_q;
				seg_wd.length = ADDR_BITS'(taken_q);
				seg_wd.in_use = 1'b1;
				seg_wd.asked  = bytes_q;
				seg_wd.grant  = ADDR_BITS'(at_q);
			end
			S_FRD: seg_ra = k_q[IW-1:0];
			S_FLRD: seg_ra = IW'(p_q - 1'b1);
			S_FRRD: seg_ra = IW'(p_q + 1'b1);
			S_FWR: begin
				seg_we        = 1'b1;
				seg_wa        = p_q;
				seg_wd.start  = cur_st_q;
				seg_wd.length = cur_len_q;
			end
			S_RMRD: fl_ra = IW'(j_q + 1'b1);
			S_RMWR: begin
				fl_we = 1'b1;
				fl_wa = j_q[IW-1:0];
				fl_wd = fl_rd_q;
			end
			S_FDRD: fl_ra = k_q[IW-1:0];
			S_OPRD: seg_ra = IW'(k_q - 1'b1);
			S_OPWR: begin
				seg_we = 1'b1;
				seg_wa = k_q[IW-1:0];
				seg_wd = seg_rd_q;
			end
			S_CLRD: seg_ra = IW'(k_q + 1'b1);
			S_CLWR: begin
				seg_we = 1'b1;
				seg_wa = k_q[IW-1:0];
				seg_wd = seg_rd_q;
			end
			S_ADRD: fl_ra = k_q[IW-1:0];
			S_ADWR: begin
				fl_we = 1'b1;
				fl_wa = k_q[IW-1:0];
				fl_wd = fl_rd_q;
				if (adj_inc_q && (CW'(fl_rd_q) >= thr_q)) begin
					fl_wd = IW'(fl_rd_q + 1'b1);
				end else if (!adj_inc_q && (CW'(fl_rd_q) > thr_q)) begin
					fl_wd = IW'(fl_rd_q - 1'b1);
				end
			end
			S_SCFL: fl_ra = k_q[IW-1:0];
			S_SCSEG: seg_ra = fl_rd_q;
			S_SHRD: begin
				if (k_q > pos_q) begin
					fl_ra = IW'(k_q - 1'b1);
				end else begin
					fl_we = 1'b1;
					fl_wa = pos_q[IW-1:0];
					fl_wd = ins_seg_q;
				end
			end
			S_SHWR: begin
				fl_we = 1'b1;
				fl_wa = k_q[IW-1:0];
				fl_wd = fl_rd_q;
			end
			default: begin
			end
		endcase
	end

	// Payload registers of the request in work
	always_ff @(posedge clk) begin
		if (req_acc) begin
			bytes_q <= req.request_bytes;
			alog_q  <= req.align_log2;
			off_q   <= req.release_offset;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ret_q        <= S_IDLE;
			pool_bytes_q <= pra_pkg::POOL_BYTES_RST;
			pool_align_q <= pra_pkg::POOL_ALIGN_RST;
			order_q      <= pra_pkg::FREE_ORDER_RST;
			seg_total_q  <= '0;
			fl_len_q     <= '0;
			live_q       <= '0;
			free_q       <= '0;
			waste_q      <= '0;
			amask_q      <= '0;
			need_q       <= '0;
			at_q         <= '0;
			taken_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			pos_q        <= '0;
			thr_q        <= '0;
			p_q          <= '0;
			target_q     <= '0;
			ins_seg_q    <= '0;
			st_q         <= '0;
			len_q        <= '0;
			cur_st_q     <= '0;
			cur_len_q    <= '0;
			ins_key_q    <= '0;
			adj_inc_q    <= 1'b0;
			res_status_q <= pra_pkg::ST_OK;
			res_grant_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= pra_pkg::ST_OK;
			out_grant_q  <= '0;
			out_free_q   <= '0;
			out_waste_q  <= '0;
			out_live_q   <= '0;
		end else begin
			// Load the result when the sequencer finishes; drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				// Rebuild the pool as one free segment, or none for a zero-byte pool
				S_INIT: begin
					seg_total_q <= CW'(size_w != '0);
					fl_len_q    <= CW'(size_w != '0);
					free_q      <= DW'(size_w);
					waste_q     <= '0;
					live_q      <= '0;
					state_q     <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						k_q     <= '0;
						state_q <= (req.req_type == pra_pkg::REQ_ALLOC) ? S_APREP : S_FRD;
					end
				end

				// Allocate: round the size, then walk the free list
				S_APREP: begin
					amask_q <= amask_w;
					need_q  <= (SW'(bytes_q) + amask_w) & ~amask_w;
					i_q     <= '0;
					if (bytes_q == '0) begin
						res_status_q <= pra_pkg::ST_NOFIT;
						res_grant_q  <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_AFL;
					end
				end
				S_AFL: begin
					if (i_q >= fl_len_q) begin
						res_status_q <= pra_pkg::ST_NOFIT;
						res_grant_q  <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_ASEG;
					end
				end
				S_ASEG: begin
					p_q <= fl_rd_q;
					if (CW'(fl_rd_q) >= seg_total_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_AFL;
					end else begin
						state_q <= S_AAT;
					end
				end
				S_AAT: begin
					st_q    <= seg_rd_q.start;
					len_q   <= seg_rd_q.length;
					at_q    <= (SW'(seg_rd_q.start) + amask_q) & ~amask_q;
					state_q <= S_ACMP;
				end
				S_ACMP: begin
					if (taken_w > SW'(len_q)) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_AFL;
					end else if ((taken_w < SW'(len_q)) &&
						(seg_total_q >= CW'(MAX_SEGMENTS))) begin
						res_status_q <= pra_pkg::ST_FULL;
						res_grant_q  <= '0;
						state_q      <= S_DONE;
					end else begin
						taken_q <= taken_w;
						j_q     <= i_q;
						ret_q   <= (taken_w < SW'(len_q)) ? S_AOPN : S_AWRP;
						state_q <= S_RMRD;
					end
				end
				S_AOPN: begin
					k_q     <= seg_total_q;
					thr_q   <= CW'(p_q) + 1'b1;
					ret_q   <= S_AWRN;
					state_q <= S_OPRD;
				end
				S_AWRN: begin
					ins_seg_q <= IW'(p_q + 1'b1);
					ins_key_q <= (order_q == pra_pkg::ORDER_SIZE) ? rem_len_w : rem_start_w;
					ret_q     <= S_AWRP;
					state_q   <= S_INS;
				end
				S_AWRP: state_q <= S_AFIN;
				S_AFIN: begin
					free_q       <= free_q - DW'(taken_q);
					waste_q      <= waste_q + (DW'(taken_q) - bytes_q);
					live_q       <= live_q + 1'b1;
					res_status_q <= pra_pkg::ST_OK;
					res_grant_q  <= DW'(at_q);
					state_q      <= S_DONE;
				end

				// Free: search the table for the live grant
				S_FRD: begin
					if (k_q < seg_total_q) begin
						state_q <= S_FCHK;
					end else begin
						res_status_q <= pra_pkg::ST_UNKNOWN;
						res_grant_q  <= '0;
						state_q      <= S_DONE;
					end
				end
				S_FCHK: begin
					if (seg_rd_q.in_use && (DW'(seg_rd_q.grant) == off_q)) begin
						p_q       <= k_q[IW-1:0];
						cur_st_q  <= seg_rd_q.start;
						cur_len_q <= seg_rd_q.length;
						free_q    <= free_q + DW'(seg_rd_q.length);
						waste_q   <= waste_q - (DW'(seg_rd_q.length) - seg_rd_q.asked);
						live_q    <= live_q - 1'b1;
						state_q   <= S_FLRD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_FLRD: state_q <= (p_q != '0) ? S_FLCHK : S_FRRD;
				S_FLCHK: begin
					if (!seg_rd_q.in_use) begin
						cur_st_q  <= seg_rd_q.start;
						cur_len_q <= cur_len_q + seg_rd_q.length;
						target_q  <= IW'(p_q - 1'b1);
						k_q       <= '0;
						ret_q     <= S_FLMRG;
						state_q   <= S_FDRD;
					end else begin
						state_q <= S_FRRD;
					end
				end
				S_FLMRG: begin
					k_q     <= CW'(p_q);
					thr_q   <= CW'(p_q);
					p_q     <= IW'(p_q - 1'b1);
					ret_q   <= S_FRRD;
					state_q <= S_CLRD;
				end
				S_FRRD: state_q <= (CW'(p_q) + 1'b1 < seg_total_q) ? S_FRCHK : S_FWR;
				S_FRCHK: begin
					if (!seg_rd_q.in_use) begin
						cur_len_q <= cur_len_q + seg_rd_q.length;
						target_q  <= IW'(p_q + 1'b1);
						k_q       <= '0;
						ret_q     <= S_FRMRG;
						state_q   <= S_FDRD;
					end else begin
						state_q <= S_FWR;
					end
				end
				S_FRMRG: begin
					k_q     <= CW'(p_q) + 1'b1;
					thr_q   <= CW'(p_q) + 1'b1;
					ret_q   <= S_FWR;
					state_q <= S_CLRD;
				end
				S_FWR: begin
					ins_seg_q    <= p_q;
					ins_key_q    <= (order_q == pra_pkg::ORDER_SIZE) ? cur_len_q : cur_st_q;
					res_status_q <= pra_pkg::ST_OK;
					res_grant_q  <= '0;
					ret_q        <= S_DONE;
					state_q      <= S_INS;
				end

				// Remove the free list entry at position j
				S_RMRD: begin
					if (j_q + 1'b1 < fl_len_q) begin
						state_q <= S_RMWR;
					end else begin
						fl_len_q <= fl_len_q - 1'b1;
						state_q  <= ret_q;
					end
				end
				S_RMWR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_RMRD;
				end

				// Find a segment index on the free list, then remove it
				S_FDRD: state_q <= (k_q < fl_len_q) ? S_FDCHK : ret_q;
				S_FDCHK: begin
					if (fl_rd_q == target_q) begin
						j_q     <= k_q;
						state_q <= S_RMRD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FDRD;
					end
				end

				// Open a table entry at thr: move entries up one
				S_OPRD: begin
					if (k_q > thr_q) begin
						state_q <= S_OPWR;
					end else begin
						seg_total_q <= seg_total_q + 1'b1;
						k_q         <= '0;
						adj_inc_q   <= 1'b1;
						state_q     <= S_ADRD;
					end
				end
				S_OPWR: begin
					k_q     <= k_q - 1'b1;
					state_q <= S_OPRD;
				end

				// Close table entry k: move entries down one
				S_CLRD: begin
					if (k_q + 1'b1 < seg_total_q) begin
						state_q <= S_CLWR;
					end else begin
						seg_total_q <= seg_total_q - 1'b1;
						k_q         <= '0;
						adj_inc_q   <= 1'b0;
						state_q     <= S_ADRD;
					end
				end
				S_CLWR: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_CLRD;
				end

				// Renumber free list entries after a table move
				S_ADRD: state_q <= (k_q < fl_len_q) ? S_ADWR : ret_q;
				S_ADWR: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_ADRD;
				end

				// Insert ins_seg into the free list in the configured order
				S_INS: begin
					if (fl_len_q >= CW'(MAX_SEGMENTS)) begin
						state_q <= ret_q;
					end else if (order_q[1]) begin
						pos_q   <= '0;
						k_q     <= fl_len_q;
						state_q <= S_SHRD;
					end else begin
						k_q     <= '0;
						state_q <= S_SCFL;
					end
				end
				S_SCFL: begin
					if (k_q < fl_len_q) begin
						state_q <= S_SCSEG;
					end else begin
						pos_q   <= k_q;
						state_q <= S_SHRD;
					end
				end
				S_SCSEG: state_q <= S_SCCMP;
				S_SCCMP: begin
					if (key_field_w <= ins_key_q) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SCFL;
					end else begin
						pos_q   <= k_q;
						k_q     <= fl_len_q;
						state_q <= S_SHRD;
					end
				end
				S_SHRD: begin
					if (k_q > pos_q) begin
						state_q <= S_SHWR;
					end else begin
						fl_len_q <= fl_len_q + 1'b1;
						state_q  <= ret_q;
					end
				end
				S_SHWR: begin
					k_q     <= k_q - 1'b1;
					state_q <= S_SHRD;
				end

				// Hold the result until the output register is free
				S_DONE: begin
					if (out_load) begin
						out_status_q <= res_status_q;
						out_grant_q  <= res_grant_q;
						out_free_q   <= free_q;
						out_waste_q  <= waste_q;
						out_live_q   <= pra_pkg::LIVE_W'(live_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Configuration writes; geometry changes rebuild the pool
			if (cfg_acc) begin
				case (cfg.index)
					pra_pkg::REG_POOL_BYTES: begin
						pool_bytes_q <= cfg.data;
						state_q      <= S_INIT;
					end
					pra_pkg::REG_POOL_ALIGN: begin
						pool_align_q <= cfg.data[pra_pkg::ALOG_W-1:0];
						state_q      <= S_INIT;
					end
					pra_pkg::REG_FREE_ORDER: order_q <= cfg.data[pra_pkg::MODE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### test/tb_pool_range_allocator_core.sv
// Testbench for pool_range_allocator_core: drives allocate and free requests,
// rewrites the configuration between phases and checks every result against a
// local predictor. Depends on pra_pkg and the channels in rtl/pra_if.sv.
`timescale 1ns / 1ps

module tb_pool_range_allocator_core;

	localparam int SEGS       = 64;
	localparam int STALL_MAX  = 17;
	localparam int WDOG_LIMIT = 20000;
	localparam int DW         = pra_pkg::DATA_W;
	localparam int AW         = pra_pkg::ALOG_W;
	localparam int MW         = pra_pkg::MODE_W;
	localparam int LW         = pra_pkg::LIVE_W;

	typedef struct {
		pra_pkg::status_t st;
		logic [DW-1:0]    grant;
		logic [DW-1:0]    freeb;
		logic [DW-1:0]    waste;
		logic [LW-1:0]    live;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	pra_req_if req_ch ();
	pra_rsp_if rsp_ch ();
	pra_cfg_if cfg_ch ();

	pool_range_allocator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted allocator state
	logic [DW-1:0]     range_bytes;
	logic [AW-1:0]     pool_alog;
	logic [MW-1:0]     order_mode;
	logic [DW-1:0]     sg_start [SEGS];
	logic [DW-1:0]     sg_len [SEGS];
	logic [DW-1:0]     sg_asked [SEGS];
	logic [DW-1:0]     sg_grant [SEGS];
	bit                sg_live [SEGS];
	int unsigned       free_order [SEGS];
	int unsigned       seg_n;
	int unsigned       free_n;
	logic [DW-1:0]     free_sum;
	logic [DW-1:0]     waste_sum;
	int unsigned       live_n;

	alloc_result_t pending_results[$];
	bit            failed;
	bit            quiet;
	int            wdog_cnt;
	int            rsp_wait;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Return the predicted pool to its empty form
	function automatic void rebuild_pool();
		for (int i = 0; i < SEGS; i++) begin
			sg_start[i] = '0;
			sg_len[i] = '0;
			sg_asked[i] = '0;
			sg_grant[i] = '0;
			sg_live[i] = 1'b0;
			free_order[i] = 0;
		end
		sg_len[0] = range_bytes;
		seg_n = (range_bytes != 0) ? 1 : 0;
		free_n = seg_n;
		free_sum = range_bytes;
		waste_sum = '0;
		live_n = 0;
	endfunction

	function automatic void order_remove(int unsigned s);
		int unsigned i;
		i = 0;
		while (i < free_n && free_order[i] != s)
			i++;
		if (i >= free_n)
			return;
		for (; i + 1 < free_n; i++)
			free_order[i] = free_order[i + 1];
		free_n--;
	endfunction

	function automatic void order_insert(int unsigned s);
		int unsigned pos;
		pos = 0;
		if (free_n >= SEGS)
			return;
		if (order_mode == pra_pkg::ORDER_SIZE) begin
			while (pos < free_n && sg_len[free_order[pos]] <= sg_len[s])
				pos++;
		end else if (order_mode == pra_pkg::ORDER_OFFSET) begin
			while (pos < free_n && sg_start[free_order[pos]] <= sg_start[s])
				pos++;
		end
		for (int unsigned i = free_n; i > pos; i--)
			free_order[i] = free_order[i - 1];
		free_order[pos] = s;
		free_n++;
	endfunction

	function automatic void move_entry(int unsigned dst, int unsigned src);
		sg_start[dst] = sg_start[src];
		sg_len[dst] = sg_len[src];
		sg_live[dst] = sg_live[src];
		sg_asked[dst] = sg_asked[src];
		sg_grant[dst] = sg_grant[src];
	endfunction

	function automatic void table_insert_at(int unsigned p);
		for (int unsigned i = seg_n; i > p; i--)
			move_entry(i, i - 1);
		seg_n++;
		for (int unsigned i = 0; i < free_n; i++)
			if (free_order[i] >= p)
				free_order[i]++;
	endfunction

	function automatic void table_delete_at(int unsigned p);
		for (int unsigned i = p; i + 1 < seg_n; i++)
			move_entry(i, i + 1);
		seg_n--;
		for (int unsigned i = 0; i < free_n; i++)
			if (free_order[i] > p)
				free_order[i]--;
	endfunction

	// First fit over the free list, splitting the taken span off the front
	function automatic pra_pkg::status_t predict_alloc(logic [DW-1:0] bytes,
			logic [AW-1:0] alog, output logic [DW-1:0] grant);
		logic [AW-1:0] l2;
		logic [63:0] step, need, st, len, at, taken;
		int unsigned p;
		grant = '0;
		l2 = (pool_alog > alog) ? pool_alog : alog;
		step = 64'd1 << l2;
		need = ({32'd0, bytes} + step - 64'd1) & ~(step - 64'd1);
		if (bytes == 0)
			return pra_pkg::ST_NOFIT;
		for (int unsigned i = 0; i < free_n; i++) begin
			p = free_order[i];
			if (p >= seg_n)
				continue;
			st = 64'(sg_start[p]);
			len = 64'(sg_len[p]);
			at = (st + step - 64'd1) & ~(step - 64'd1);
			taken = (at - st) + need;
			if (taken > len)
				continue;
			if (taken < len) begin
				if (seg_n >= SEGS)
					return pra_pkg::ST_FULL;
				order_remove(p);
				table_insert_at(p + 1);
				sg_start[p + 1] = DW'(st + taken);
				sg_len[p + 1] = DW'(len - taken);
				sg_live[p + 1] = 1'b0;
				sg_asked[p + 1] = '0;
				sg_grant[p + 1] = '0;
				order_insert(p + 1);
			end else begin
				order_remove(p);
			end
			sg_len[p] = DW'(taken);
			sg_live[p] = 1'b1;
			sg_asked[p] = bytes;
			sg_grant[p] = DW'(at);
			free_sum -= DW'(taken);
			waste_sum += DW'(taken) - bytes;
			live_n++;
			grant = DW'(at);
			return pra_pkg::ST_OK;
		end
		return pra_pkg::ST_NOFIT;
	endfunction

	// Release a live grant and merge it with free neighbors
	function automatic pra_pkg::status_t predict_release(logic [DW-1:0] off);
		int unsigned p;
		p = 0;
		while (p < seg_n && !(sg_live[p] && sg_grant[p] == off))
			p++;
		if (p >= seg_n)
			return pra_pkg::ST_UNKNOWN;
		free_sum += sg_len[p];
		waste_sum -= sg_len[p] - sg_asked[p];
		live_n--;
		sg_live[p] = 1'b0;
		sg_asked[p] = '0;
		sg_grant[p] = '0;
		if (p > 0 && !sg_live[p - 1]) begin
			order_remove(p - 1);
			sg_len[p - 1] += sg_len[p];
			table_delete_at(p);
			p--;
		end
		if (p + 1 < seg_n && !sg_live[p + 1]) begin
			order_remove(p + 1);
			sg_len[p] += sg_len[p + 1];
			table_delete_at(p + 1);
		end
		order_insert(p);
		return pra_pkg::ST_OK;
	endfunction

	// Pick the grant offset of a random live allocation; returns 0 if none
	function automatic bit pick_live_grant(output logic [DW-1:0] off);
		int unsigned idx[$];
		off = '0;
		for (int unsigned i = 0; i < seg_n; i++)
			if (sg_live[i])
				idx.insert(idx.size(), i);
		if (idx.size() == 0)
			return 1'b0;
		off = sg_grant[idx[$urandom_range(0, idx.size() - 1)]];
		return 1'b1;
	endfunction

	// Send one request, then record its predicted result
	task automatic send_request(logic typ, logic [DW-1:0] bytes, logic [AW-1:0] alog,
			logic [DW-1:0] off);
		int gap;
		alloc_result_t r;
		gap = quiet ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= typ;
		req_ch.request_bytes <= bytes;
		req_ch.align_log2 <= alog;
		req_ch.release_offset <= off;
		do @(posedge clk); while (!req_ch.ready);
		if (typ == pra_pkg::REQ_ALLOC)
			r.st = predict_alloc(bytes, alog, r.grant);
		else begin
			r.st = predict_release(off);
			r.grant = '0;
		end
		r.freeb = free_sum;
		r.waste = waste_sum;
		r.live = LW'(live_n);
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic send_alloc(logic [DW-1:0] bytes, logic [AW-1:0] alog);
		send_request(pra_pkg::REQ_ALLOC, bytes, alog, DW'($urandom));
	endtask

	task automatic send_release(logic [DW-1:0] off);
		send_request(pra_pkg::REQ_FREE, DW'($urandom), AW'($urandom), off);
	endtask

	// Drop valid and hold until every predicted result has been seen
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [pra_pkg::CIDX_W-1:0] idx, logic [DW-1:0] value);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == pra_pkg::REG_POOL_BYTES) begin
			range_bytes = value;
			rebuild_pool();
		end else if (idx == pra_pkg::REG_POOL_ALIGN) begin
			pool_alog = AW'(value);
			rebuild_pool();
		end else if (idx == pra_pkg::REG_FREE_ORDER)
			order_mode = MW'(value);
		@(posedge clk);
	endtask

	task automatic set_geometry(logic [DW-1:0] bytes, logic [AW-1:0] alog,
			logic [MW-1:0] mode);
		write_reg(pra_pkg::REG_POOL_BYTES, bytes);
		write_reg(pra_pkg::REG_POOL_ALIGN, DW'(alog));
		write_reg(pra_pkg::REG_FREE_ORDER, DW'(mode));
	endtask

	// Reset geometry: zero size, extremes of size and alignment, bad frees
	task automatic test_basic_requests();
		logic [DW-1:0] off;
		send_alloc(32'd0, 5'd0);
		send_alloc(32'd1, 5'd0);
		send_alloc(32'd300, 5'd16);
		send_alloc(32'hFFFF_FFFF, 5'd0);
		send_alloc(32'd65536, 5'd0);
		send_release(32'h1234_5670);
		if (pick_live_grant(off))
			send_release(off);
		send_release(off);
		send_alloc(32'd1000, 5'd10);
		if (pick_live_grant(off))
			send_release(off);
		if (pick_live_grant(off))
			send_release(off);
	endtask

	// Empty pool, one-byte pool and a full-range pool with an alignment of 2^16
	task automatic test_geometry_extremes();
		set_geometry(32'd0, 5'd0, pra_pkg::ORDER_OFFSET);
		send_alloc(32'd1, 5'd0);
		send_release(32'd0);
		set_geometry(32'd1, 5'd0, pra_pkg::ORDER_SIZE);
		send_alloc(32'd1, 5'd0);
		send_alloc(32'd1, 5'd0);
		send_release(32'd0);
		set_geometry(32'hFFFF_FFFF, 5'd16, 2'd3);
		send_alloc(32'h8000_0000, 5'd16);
		send_alloc(32'h7FFF_0000, 5'd16);
		send_alloc(32'h7FFE_0001, 5'd0);
		send_release(32'd0);
	endtask

	// Fill the segment table, then exact-fit the remainder and coalesce
	task automatic test_table_full();
		set_geometry(32'd65536, 5'd8, pra_pkg::ORDER_OFFSET);
		for (int i = 0; i < SEGS; i++)
			send_alloc(32'd256, 5'd0);
		send_alloc(32'd65536 - 32'd16128, 5'd0);
		send_release(32'd512);
		send_release(32'd1024);
		send_release(32'd768);
		send_alloc(32'd700, 5'd0);
	endtask

	// Random traffic over several settings: mostly live churn plus some noise
	task automatic test_random_traffic();
		logic [DW-1:0] sizes [7] = '{32'd65536, 32'd65536, 32'd4096, 32'd65536,
			32'hFFFF_FFFF, 32'd2048, 32'd100000};
		logic [AW-1:0] aligns [7] = '{5'd8, 5'd8, 5'd0, 5'd4, 5'd16, 5'd2, 5'd12};
		logic [MW-1:0] modes [7] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2};
		logic [DW-1:0] off, cap;
		int pick;
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 2 || ph == 5)
				write_reg(pra_pkg::REG_FREE_ORDER, DW'(modes[ph]));
			else
				set_geometry(sizes[ph], aligns[ph], modes[ph]);
			quiet = (ph == 3);
			cap = (sizes[ph] >> 3) + 32'd1;
			for (int n = 0; n < 66; n++) begin
				if (n == 33)
					drain_results();
				pick = $urandom_range(0, 99);
				if (pick < 55)
					send_alloc(DW'($urandom_range(1, cap)), AW'($urandom_range(0, 16)));
				else if (pick < 88 && pick_live_grant(off))
					send_release(off);
				else if (pick < 92)
					send_release(DW'($urandom));
				else if (pick < 95)
					send_alloc(DW'($urandom), AW'($urandom_range(0, 16)));
				else
					send_alloc(DW'($urandom_range(0, 3)), AW'($urandom_range(0, 16)));
			end
			quiet = 1'b0;
		end
	endtask

	// Result side: random stalls, compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		logic nxt_ready;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_wait = 0;
		end else begin
			nxt_ready = rsp_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d", $time, rsp_ch.status);
					failed = 1'b1;
				end else begin
					e = pending_results.pop_front();
					if (rsp_ch.status !== e.st) begin
						$display("%0t: status exp %0d act %0d", $time, e.st, rsp_ch.status);
						failed = 1'b1;
					end
					if (rsp_ch.grant_offset !== e.grant) begin
						$display("%0t: grant_offset exp %h act %h", $time, e.grant,
							rsp_ch.grant_offset);
						failed = 1'b1;
					end
					if (rsp_ch.free_bytes !== e.freeb) begin
						$display("%0t: free_bytes exp %h act %h", $time, e.freeb,
							rsp_ch.free_bytes);
						failed = 1'b1;
					end
					if (rsp_ch.waste_bytes !== e.waste) begin
						$display("%0t: waste_bytes exp %h act %h", $time, e.waste,
							rsp_ch.waste_bytes);
						failed = 1'b1;
					end
					if (rsp_ch.live_count !== e.live) begin
						$display("%0t: live_count exp %0d act %0d", $time, e.live,
							rsp_ch.live_count);
						failed = 1'b1;
					end
				end
				rsp_wait = quiet ? 0 : $urandom_range(0, STALL_MAX);
				nxt_ready = (rsp_wait == 0);
			end else if (rsp_wait > 0) begin
				rsp_wait--;
				nxt_ready = (rsp_wait == 0);
			end else
				nxt_ready = 1'b1;
			rsp_ch.ready <= nxt_ready;
		end
	end

	// Watchdog: end the run if no handshake happens for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || !arst_n)
			wdog_cnt <= 0;
		else if (wdog_cnt >= WDOG_LIMIT) begin
			$display("tb_pool_range_allocator_core: FAIL");
			$finish;
		end else
			wdog_cnt <= wdog_cnt + 1;
	end

	initial begin
		failed = 1'b0;
		quiet = 1'b0;
		wdog_cnt = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= pra_pkg::REQ_ALLOC;
		req_ch.request_bytes <= '0;
		req_ch.align_log2 <= '0;
		req_ch.release_offset <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= pra_pkg::REG_POOL_BYTES;
		cfg_ch.data <= '0;
		range_bytes = pra_pkg::POOL_BYTES_RST;
		pool_alog = pra_pkg::POOL_ALIGN_RST;
		order_mode = pra_pkg::FREE_ORDER_RST;
		rebuild_pool();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_requests();
		test_geometry_extremes();
		test_table_full();
		test_random_traffic();

		drain_results();
		repeat (200) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("tb_pool_range_allocator_core: PASS");
		else
			$display("tb_pool_range_allocator_core: FAIL");
		$finish;
	end

endmodule
